[hdl/dead_reckoning_pose_update_assert.svh]
// assertion macros shared by the pose update rtl
// clock and active-low reset are passed in by the caller
`ifndef DEAD_RECKONING_POSE_UPDATE_ASSERT_SVH
`define DEAD_RECKONING_POSE_UPDATE_ASSERT_SVH

// same-cycle implication
`define DRP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DRP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/drp_pkg.sv]
// shared types, constants and angle helpers for the pose update block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

    localparam int POS_W      = 24;
    localparam int DIST_W     = 16;
    localparam int TURN_W     = 11;
    localparam int HEAD_W     = 9;
    localparam int REM_W      = 7;
    localparam int TRIG_W     = 32;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [HEAD_W-1:0] DEG_FULL = 9'd360;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [TRIG_W-1:0] DEG_TO_RAD_Q30 = 32'd18740330;

    // atan(2^-i) in q2.30
    localparam logic signed [TRIG_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
        32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
        32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
        32'sd4194282,   32'sd2097149,   32'sd1048575,   32'sd524287,
        32'sd262143,    32'sd131071,    32'sd65535,     32'sd32767,
        32'sd16383,     32'sd8191,      32'sd4095,      32'sd2047,
        32'sd1023,      32'sd511,       32'sd255,       32'sd127
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROTATE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_DONE
    } drp_state_t;

    typedef struct packed {
        logic [1:0]       quadrant;
        logic [REM_W-1:0] remainder;
    } drp_angle_t;

    typedef struct packed {
        logic       start;
        drp_angle_t angle;
    } drp_cordic_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } drp_cordic_status_t;

    // wrap a signed angle in -1024..1382 into 0..359
    function automatic logic [HEAD_W-1:0] wrap_deg(input logic signed [11:0] a);
        logic [11:0] v;
        v = 12'($signed(a) + 12'sd1440);
        if (v >= 12'd1440) v = v - 12'd1440;
        if (v >= 12'd720)  v = v - 12'd720;
        if (v >= 12'd360)  v = v - 12'd360;
        return v[HEAD_W-1:0];
    endfunction

    // split a heading 0..359 into quadrant and remainder 0..89
    function automatic drp_angle_t split_deg(input logic [HEAD_W-1:0] h);
        drp_angle_t   res;
        logic [HEAD_W-1:0] v;
        v = h;
        res.quadrant[1] = (v >= 9'd180);
        if (res.quadrant[1]) v = v - 9'd180;
        res.quadrant[0] = (v >= 9'd90);
        if (res.quadrant[0]) v = v - 9'd90;
        res.remainder = v[REM_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/dead_reckoning_pose_update.sv]
// sequence: a move request passes ST_START, ST_ROTATE, ST_MUL_X, ST_MUL_Y, ST_ADD_Y and
// ST_DONE, ST_ROTATE waiting on the cordic unit doing one micro-rotation per cycle;
// a load request goes straight to ST_DONE; one request at a time, the next is taken the
// cycle after the result is registered; ST_DONE holds while the output register is full
// reset: synchronous active-low aresetn clears the pose to x = 0, y = 0, heading = 0
// and empties the output register
`timescale 1ns / 1ps
`default_nettype none
`include "dead_reckoning_pose_update_assert.svh"

module dead_reckoning_pose_update #(
    parameter int CORDIC_STEPS = drp_pkg::CORDIC_STEPS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // distance[15:0], turn_amount[26:16], load_x[50:27], load_y[74:51],
    // load_heading[85:75], target_heading[94:86], zero pad[95]
    input  wire  [95:0] s_axis_tdata,
    // action: 0 move, 1 load pose
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // pos_x[23:0], pos_y[47:24], heading_deg[56:48], turn_to_target[65:57],
    // zero pad[71:66]
    output logic [71:0] m_axis_tdata,
    // saturated
    output logic        m_axis_tuser
);
    import drp_pkg::*;

    localparam int PROD_W = DIST_W + 1 + TRIG_W;
    localparam int STEP_D_W = PROD_W - 30;
    localparam int SUM_W = POS_W + 2;
    localparam logic signed [SUM_W-1:0] POS_MAX_EXT = 26'sd8388607;
    localparam logic signed [SUM_W-1:0] POS_MIN_EXT = -26'sd8388608;

    // input request fields
    logic [DIST_W-1:0]        in_distance;
    logic signed [TURN_W-1:0] in_turn;
    logic signed [POS_W-1:0]  in_load_x;
    logic signed [POS_W-1:0]  in_load_y;
    logic signed [TURN_W-1:0] in_load_heading;
    logic [HEAD_W-1:0]        in_target;

    assign in_distance     = s_axis_tdata[15:0];
    assign in_turn         = s_axis_tdata[26:16];
    assign in_load_x       = s_axis_tdata[50:27];
    assign in_load_y       = s_axis_tdata[74:51];
    assign in_load_heading = s_axis_tdata[85:75];
    assign in_target       = s_axis_tdata[94:86];

    drp_state_t state_reg, state_next;

    // pose state
    logic signed [POS_W-1:0] x_pos_reg;
    logic signed [POS_W-1:0] y_pos_reg;
    logic [HEAD_W-1:0]       heading_reg;
    logic                    sat_reg;

    // per-request working registers
    logic [DIST_W-1:0]        dist_reg;
    logic [HEAD_W-1:0]        target_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // output register
    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  out_x_reg;
    logic signed [POS_W-1:0]  out_y_reg;
    logic [HEAD_W-1:0]        out_heading_reg;
    logic signed [HEAD_W-1:0] out_turn_reg;
    logic                     out_sat_reg;

    logic s_accept;
    logic out_load;

    drp_cordic_ctrl_t         cordic_ctrl;
    drp_cordic_status_t       cordic_status;
    logic signed [TRIG_W-1:0] cos_q30;
    logic signed [TRIG_W-1:0] sin_q30;

    logic [HEAD_W-1:0]          move_heading;
    logic signed [TRIG_W-1:0]   mul_operand;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_rounded;
    logic signed [STEP_D_W-1:0] travel_step;
    logic signed [POS_W-1:0]    pos_sel;
    logic signed [SUM_W-1:0]    pos_sum;
    logic signed [POS_W-1:0]    pos_next;
    logic                       pos_clip;
    logic signed [10:0]         turn_raw;
    logic signed [10:0]         turn_fixed;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    // sin/cos unit: started once per move request
    assign cordic_ctrl.start = (state_reg == ST_START);
    assign cordic_ctrl.angle = split_deg(heading_reg);

    drp_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cordic_ctrl),
        .status  (cordic_status),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    // heading after the turn of a move request
    assign move_heading = wrap_deg(12'($signed({3'b000, heading_reg})) + 12'(in_turn));

    // one multiplier shared between the x and y travel products
    always_comb begin
        mul_operand  = (state_reg == ST_MUL_X) ? cos_q30 : sin_q30;
        prod_next    = PROD_W'($signed({1'b0, dist_reg}) * mul_operand);
        // round half up, then drop the q2.30 fraction
        prod_rounded = prod_reg + (PROD_W'(1) <<< 29);
        travel_step  = prod_rounded[PROD_W-1:30];
        pos_sel      = (state_reg == ST_MUL_Y) ? x_pos_reg : y_pos_reg;
        pos_sum      = SUM_W'(pos_sel) + SUM_W'(travel_step);
        pos_clip     = 1'b0;
        if (pos_sum > POS_MAX_EXT) begin
            pos_next = POS_MAX_EXT[POS_W-1:0];
            pos_clip = 1'b1;
        end else if (pos_sum < POS_MIN_EXT) begin
            pos_next = POS_MIN_EXT[POS_W-1:0];
            pos_clip = 1'b1;
        end else begin
            pos_next = pos_sum[POS_W-1:0];
        end
    end

    // shortest signed turn from the new heading to the target
    always_comb begin
        turn_raw = $signed({2'b00, target_reg}) - $signed({2'b00, heading_reg});
        if (turn_raw < -11'sd180) begin
            turn_fixed = turn_raw + 11'sd360;
        end else if (turn_raw > 11'sd180) begin
            turn_fixed = turn_raw - 11'sd360;
        end else begin
            turn_fixed = turn_raw;
        end
    end

    // the output register is free when empty or being drained
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer next state and handshake
    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    state_next = s_axis_tuser ? ST_DONE : ST_START;
                end
            end
            ST_START: begin
                state_next = ST_ROTATE;
            end
            ST_ROTATE: begin
                if (cordic_status.done) begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                state_next = ST_ADD_Y;
            end
            ST_ADD_Y: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pose registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_pos_reg   <= '0;
            y_pos_reg   <= '0;
            heading_reg <= '0;
        end else begin
            if (s_accept) begin
                if (s_axis_tuser) begin
                    x_pos_reg   <= in_load_x;
                    y_pos_reg   <= in_load_y;
                    heading_reg <= wrap_deg(12'(in_load_heading));
                end else begin
                    heading_reg <= move_heading;
                end
            end
            if (state_reg == ST_MUL_Y) begin
                x_pos_reg <= pos_next;
            end
            if (state_reg == ST_ADD_Y) begin
                y_pos_reg <= pos_next;
            end
        end
    end

    // per-request working registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dist_reg   <= in_distance;
            target_reg <= in_target;
            sat_reg    <= 1'b0;
        end else if ((state_reg == ST_MUL_Y) || (state_reg == ST_ADD_Y)) begin
            sat_reg <= sat_reg | pos_clip;
        end
        if ((state_reg == ST_MUL_X) || (state_reg == ST_MUL_Y)) begin
            prod_reg <= prod_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg       <= x_pos_reg;
            out_y_reg       <= y_pos_reg;
            out_heading_reg <= heading_reg;
            out_turn_reg    <= turn_fixed[HEAD_W-1:0];
            out_sat_reg     <= sat_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_turn_reg, out_heading_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_sat_reg;

    // checks
    `DRP_ASSERT_IMP(a_ready_cordic_idle, aclk, aresetn, s_axis_tready, !cordic_status.busy, "request taken while cordic busy")
    `DRP_ASSERT_IMP(a_heading_range, aclk, aresetn, 1'b1, heading_reg < DEG_FULL, "heading outside 0..359")
    `DRP_ASSERT_IMP(a_done_in_rotate, aclk, aresetn, cordic_status.done, state_reg == ST_ROTATE, "cordic done outside rotate")
    `DRP_ASSERT_NXT(a_load_direct, aclk, aresetn, s_accept && s_axis_tuser, state_reg == ST_DONE, "load request did not finish at once")
    `DRP_ASSERT_IMP(a_turn_range, aclk, aresetn, out_valid_reg, (out_turn_reg >= -9'sd180) && (out_turn_reg <= 9'sd180), "turn to target out of range")

endmodule

`default_nettype wire

[hdl/drp_cordic.sv]
// iterative rotation-mode cordic, one micro-rotation per cycle
// gives cos and sin of a whole-degree angle in q2.30; uses drp_pkg
`timescale 1ns / 1ps
`default_nettype none

module drp_cordic #(
    parameter int CORDIC_STEPS = drp_pkg::CORDIC_STEPS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  drp_pkg::drp_cordic_ctrl_t      ctrl,
    output drp_pkg::drp_cordic_status_t    status,
    output logic signed [drp_pkg::TRIG_W-1:0] cos_q30,
    output logic signed [drp_pkg::TRIG_W-1:0] sin_q30
);
    import drp_pkg::*;

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [1:0]               quad_reg;
    logic signed [TRIG_W-1:0] x_reg;
    logic signed [TRIG_W-1:0] y_reg;
    logic signed [TRIG_W-1:0] z_reg;

    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    logic signed [TRIG_W-1:0] atan_val;
    logic [TRIG_W-1:0]        z_init;
    logic                     last_step;

    // shared micro-rotation datapath
    always_comb begin
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        atan_val  = ATAN_Q30[ATAN_IDX_W'(step_reg)];
        z_init    = TRIG_W'(TRIG_W'(ctrl.angle.remainder) * DEG_TO_RAD_Q30);
        last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= !ctrl.start && busy_reg && last_step;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (last_step) begin
                    busy_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= $signed(z_init);
            quad_reg <= ctrl.angle.quadrant;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_val;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_val;
            end
        end
    end

    // quadrant fold-out
    always_comb begin
        unique case (quad_reg)
            2'd0: begin
                cos_q30 = x_reg;
                sin_q30 = y_reg;
            end
            2'd1: begin
                cos_q30 = -y_reg;
                sin_q30 = x_reg;
            end
            2'd2: begin
                cos_q30 = -x_reg;
                sin_q30 = -y_reg;
            end
            default: begin
                cos_q30 = y_reg;
                sin_q30 = -x_reg;
            end
        endcase
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire
